/* rtl/typed_frame_receiver_unit_assert.svh */
// Assertion macros used by the checker of the typed frame receiver.
// Each macro expects signals named clock and reset in the using scope.
`ifndef TYPED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define TYPED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tfr_pkg.sv */
`timescale 1ns / 1ps
// Package of the typed frame receiver: widths, status and register codes,
// reset values, the result record type and the frame length clamp.
package tfr_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 64;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int POS_W      = 7;
   localparam int IDX_W      = 6;
   localparam int IDLE_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_VALUE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIG_TYPE_CODE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_TYPE_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIG_FRAME_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_FRAME_LENGTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS         = 3'd5;

   localparam logic [BYTE_W-1:0] MAGIC_RESET         = 8'd170;
   localparam logic [BYTE_W-1:0] CONFIG_CODE_RESET   = 8'd1;
   localparam logic [BYTE_W-1:0] VELOCITY_CODE_RESET = 8'd2;
   localparam logic [LEN_W-1:0]  CONFIG_LEN_RESET    = 7'd16;
   localparam logic [LEN_W-1:0]  VELOCITY_LEN_RESET  = 7'd8;
   localparam logic [IDLE_W-1:0] TIMEOUT_RESET       = 16'd3000;

   localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 7'd3;
   localparam logic [LEN_W-1:0]  MAX_FRAME_LEN = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [IDLE_W-1:0] IDLE_MAX      = {IDLE_W{1'b1}};

   localparam logic KIND_CONFIG   = 1'b0;
   localparam logic KIND_VELOCITY = 1'b1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   byte_out;
      logic [IDX_W-1:0]    byte_index;
      logic                frame_kind;
   } result_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] result;
      if (value < MIN_FRAME_LEN) begin
         result = MIN_FRAME_LEN;
      end else if (value > MAX_FRAME_LEN) begin
         result = MAX_FRAME_LEN;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

/* rtl/typed_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// Typed frame receiver: takes one UART byte or one time tick per request and
// checks the magic byte, the frame type and the frame length set by that type.
// Every byte request gives one response with the byte, its index in the frame
// and the frame kind; the last byte is marked complete, and a bad magic byte,
// an unknown type or an idle timeout inside a frame gives an error response and
// restarts the frame. A tick request gives a response only on timeout. Each
// request is decided in the cycle it is accepted and its response sits in one
// output register, so one request per cycle is taken as long as that register
// is drained; the response is valid in the cycle after acceptance.
// Registers must be written through the csr_ port only while the block is idle; it does not check this.
// Depends on tfr_pkg.
module typed_frame_receiver_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [tfr_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tfr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tfr_pkg::BYTE_W-1:0]     rsp_byte_out,
   output logic [tfr_pkg::IDX_W-1:0]      rsp_byte_index,
   output logic                           rsp_frame_kind,
   input  logic                           csr_wr_en,
   input  logic [tfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tfr_pkg::*;

   logic [BYTE_W-1:0] magic_ff;
   logic [BYTE_W-1:0] config_code_ff;
   logic [BYTE_W-1:0] velocity_code_ff;
   logic [LEN_W-1:0]  config_len_ff;
   logic [LEN_W-1:0]  velocity_len_ff;
   logic [IDLE_W-1:0] timeout_ff;

   logic [POS_W-1:0]  bytes_received_ff, bytes_received_in;
   logic [LEN_W-1:0]  expected_len_ff, expected_len_in;
   logic              kind_ff, kind_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;

   logic              req_fire;
   logic              has_result;
   logic [IDLE_W-1:0] idle_inc;
   logic [IDLE_W-1:0] limit;
   logic              last_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign idle_inc  = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 1'b1;
   assign limit     = (timeout_ff == '0) ? IDLE_W'(1) : timeout_ff;
   assign last_byte = ({1'b0, bytes_received_ff} + 8'd1) >= {1'b0, expected_len_ff};

   always_comb begin
      bytes_received_in = bytes_received_ff;
      expected_len_in   = expected_len_ff;
      kind_in           = kind_ff;
      idle_in           = idle_ff;
      has_result        = 1'b0;
      result_in         = '0;
      if (req_cmd == CMD_TICK) begin
         if (bytes_received_ff == '0) begin
            idle_in = '0;
         end else begin
            idle_in = idle_inc;
            if (idle_inc >= limit) begin
               has_result           = 1'b1;
               result_in.status     = STATUS_TIMEOUT;
               result_in.byte_out   = '0;
               result_in.byte_index = bytes_received_ff[IDX_W-1:0];
               result_in.frame_kind = (bytes_received_ff >= POS_W'(2)) ? kind_ff : KIND_CONFIG;
               bytes_received_in    = '0;
               expected_len_in      = MAX_FRAME_LEN;
               kind_in              = KIND_CONFIG;
               idle_in              = '0;
            end
         end
      end else begin
         idle_in              = '0;
         has_result           = 1'b1;
         result_in.byte_out   = req_rx_byte;
         result_in.byte_index = bytes_received_ff[IDX_W-1:0];
         if (bytes_received_ff == POS_W'(0)) begin
            result_in.frame_kind = KIND_CONFIG;
            if (req_rx_byte != magic_ff) begin
               result_in.status = STATUS_BAD_MAGIC;
               expected_len_in  = MAX_FRAME_LEN;
               kind_in          = KIND_CONFIG;
            end else begin
               result_in.status  = STATUS_ACCEPTED;
               bytes_received_in = POS_W'(1);
            end
         end else if (bytes_received_ff == POS_W'(1)) begin
            if (req_rx_byte == config_code_ff) begin
               result_in.status     = STATUS_ACCEPTED;
               result_in.frame_kind = KIND_CONFIG;
               kind_in              = KIND_CONFIG;
               expected_len_in      = clamp_len(config_len_ff);
               bytes_received_in    = POS_W'(2);
            end else if (req_rx_byte == velocity_code_ff) begin
               result_in.status     = STATUS_ACCEPTED;
               result_in.frame_kind = KIND_VELOCITY;
               kind_in              = KIND_VELOCITY;
               expected_len_in      = clamp_len(velocity_len_ff);
               bytes_received_in    = POS_W'(2);
            end else begin
               result_in.status     = STATUS_BAD_TYPE;
               result_in.frame_kind = KIND_CONFIG;
               bytes_received_in    = '0;
               expected_len_in      = MAX_FRAME_LEN;
               kind_in              = KIND_CONFIG;
            end
         end else begin
            result_in.frame_kind = kind_ff;
            if (last_byte) begin
               result_in.status  = STATUS_COMPLETE;
               bytes_received_in = '0;
               expected_len_in   = MAX_FRAME_LEN;
               kind_in           = KIND_CONFIG;
            end else begin
               result_in.status  = STATUS_ACCEPTED;
               bytes_received_in = bytes_received_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (req_fire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_received_ff <= '0;
         expected_len_ff   <= MAX_FRAME_LEN;
         kind_ff           <= KIND_CONFIG;
         idle_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            bytes_received_ff <= bytes_received_in;
            expected_len_ff   <= expected_len_in;
            kind_ff           <= kind_in;
            idle_ff           <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff         <= MAGIC_RESET;
         config_code_ff   <= CONFIG_CODE_RESET;
         velocity_code_ff <= VELOCITY_CODE_RESET;
         config_len_ff    <= CONFIG_LEN_RESET;
         velocity_len_ff  <= VELOCITY_LEN_RESET;
         timeout_ff       <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAGIC_VALUE:           magic_ff         <= csr_wdata[BYTE_W-1:0];
            CSR_CONFIG_TYPE_CODE:      config_code_ff   <= csr_wdata[BYTE_W-1:0];
            CSR_VELOCITY_TYPE_CODE:    velocity_code_ff <= csr_wdata[BYTE_W-1:0];
            CSR_CONFIG_FRAME_LENGTH:   config_len_ff    <= csr_wdata[LEN_W-1:0];
            CSR_VELOCITY_FRAME_LENGTH: velocity_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_TIMEOUT_TICKS:         timeout_ff       <= csr_wdata[IDLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = result_ff.status;
   assign rsp_byte_out   = result_ff.byte_out;
   assign rsp_byte_index = result_ff.byte_index;
   assign rsp_frame_kind = result_ff.frame_kind;

endmodule

/* rtl/tfr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for typed_frame_receiver_unit, attached by bind.
// Depends on tfr_pkg and typed_frame_receiver_unit_assert.svh.
`include "typed_frame_receiver_unit_assert.svh"

module tfr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tfr_pkg::STATUS_W-1:0]   rsp_status,
   input logic [tfr_pkg::BYTE_W-1:0]     rsp_byte_out,
   input logic [tfr_pkg::IDX_W-1:0]      rsp_byte_index,
   input logic                           rsp_frame_kind
);
   import tfr_pkg::*;

   `TFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_byte_out) && $stable(rsp_byte_index),
      "Response changed while stalled.")
   `TFR_ASSERT_SAME(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready,
      "Request taken while the response register is full and stalled.")
   `TFR_ASSERT_SAME(a_timeout_zero, rsp_valid && rsp_status == STATUS_TIMEOUT,
      rsp_byte_out == '0, "Timeout response carries a nonzero byte.")
   `TFR_ASSERT_SAME(a_bad_type_pos, rsp_valid && rsp_status == STATUS_BAD_TYPE,
      rsp_byte_index == IDX_W'(1) && rsp_frame_kind == KIND_CONFIG,
      "Bad type response at the wrong position or kind.")

endmodule

bind typed_frame_receiver_unit tfr_checker u_tfr_checker (.*);
